// ----- rtl/ffbha_pkg.sv -----
// Package for the first-fit block heap allocator.
// Holds opcodes, status codes, the controller-to-datapath command set and
// the datapath status struct. No dependencies.
package ffbha_pkg;

    localparam int OPC_W  = 2;
    localparam int SIZE_W = 21;
    localparam int ADDR_W = 32;
    localparam int ST_W   = 2;

    localparam logic [OPC_W-1:0] OP_ALLOC         = 2'd0;
    localparam logic [OPC_W-1:0] OP_ALLOC_ALIGNED = 2'd1;
    localparam logic [OPC_W-1:0] OP_FREE          = 2'd2;
    localparam logic [OPC_W-1:0] OP_RSVD          = 2'd3;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_SPACE = 2'd1;
    localparam logic [ST_W-1:0] ST_UNKNOWN  = 2'd2;

    localparam logic [ADDR_W-1:0] HEAP_BASE_RESET = 32'd20971520;

    // Micro-operations issued by the controller
    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_RD_K,
        DP_K_INC,
        DP_HIT,
        DP_RD_LAST,
        DP_GROW,
        DP_PAD_BLK,
        DP_APPEND,
        DP_ERR_SPACE,
        DP_ERR_ADDR,
        DP_MARK,
        DP_RD_KM1,
        DP_ABS_B,
        DP_RD_KP1,
        DP_ABS_F,
        DP_RD_J1,
        DP_WR_J,
        DP_DEC_COUNT,
        DP_PUSH
    } t_dp_cmd;

    // Flags the datapath reports back
    typedef struct packed {
        logic [OPC_W-1:0] op;
        logic             scan_end;
        logic             hit;
        logic             match;
        logic             q_free;
        logic             fits;
        logic             pad_nz;
        logic             tbl_empty;
        logic             k_zero;
        logic             k_last;
        logic             j_last;
    } t_dp_status;

endpackage

// ----- rtl/first_fit_block_heap_allocator.sv -----
// Top level of the first-fit block heap allocator with coalescing.
// Joins ffbha_controller and ffbha_datapath; uses ffbha_pkg.
//
//  channel   direction  handshake                    payload
//  s_*       in         s_tvalid / s_tready          request item (s_tdata)
//  m_*       out        m_tvalid / m_tready          result item (m_tdata)
//  apb       in         psel, penable, pwrite        heap_base at address 0
//
// Per item: alloc scans the table entry by entry and appends on a miss;
// free scans entries to the match, checks neighbors and shifts entries down
// on each merge. Table accesses go one at a time through the table memory.
// Reset is synchronous and clears the table count and heap top; no clearing
// pass. A new item is taken while a result waits in the output register.
// ALIGN_BYTES must be a power of two.
module first_fit_block_heap_allocator
    import ffbha_pkg::*;
#(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEAP_BYTES   = 1048576,
    parameter int HEADER_BYTES = 12,
    parameter int ALIGN_BYTES  = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] opcode, [22:2] alloc_size, [54:23] free_address, [55] zero
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] payload_address, [33:32] status, [39:34] zero
    output logic [39:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_dp_cmd           cmd;
    t_dp_status        dp_status;
    logic [ADDR_W-1:0] heap_base;
    logic [ADDR_W-1:0] res_addr;
    logic [ST_W-1:0]   res_st;
    logic              cfg_we;

    // Register write decode
    assign cfg_we = psel && penable && pwrite && (paddr == 3'd0);
    assign pready = 1'b1;
    assign prdata = (paddr == 3'd0) ? heap_base : '0;

    ffbha_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_tvalid),
        .o_in_ready  (s_tready),
        .o_out_valid (m_tvalid),
        .i_out_ready (m_tready),
        .i_status    (dp_status),
        .o_cmd       (cmd)
    );

    ffbha_datapath #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .ALIGN_BYTES  (ALIGN_BYTES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (dp_status),
        .i_opcode          (s_tdata[1:0]),
        .i_alloc_size      (s_tdata[22:2]),
        .i_free_address    (s_tdata[54:23]),
        .i_cfg_we          (cfg_we),
        .i_cfg_data        (pwdata),
        .o_heap_base       (heap_base),
        .o_payload_address (res_addr),
        .o_status_code     (res_st)
    );

    assign m_tdata = {6'd0, res_st, res_addr};

endmodule

// ----- rtl/ffbha_datapath.sv -----
// Datapath of the heap allocator: block table memory, heap top, counters,
// size/pad arithmetic and the result register.
// Depends on ffbha_pkg.
module ffbha_datapath
    import ffbha_pkg::*;
#(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEAP_BYTES   = 1048576,
    parameter int HEADER_BYTES = 12,
    parameter int ALIGN_BYTES  = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_status        o_status,
    input  logic [OPC_W-1:0]  i_opcode,
    input  logic [SIZE_W-1:0] i_alloc_size,
    input  logic [ADDR_W-1:0] i_free_address,
    input  logic              i_cfg_we,
    input  logic [ADDR_W-1:0] i_cfg_data,
    output logic [ADDR_W-1:0] o_heap_base,
    output logic [ADDR_W-1:0] o_payload_address,
    output logic [ST_W-1:0]   o_status_code
);

    localparam int IW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW  = $clog2(MAX_BLOCKS + 1);
    localparam int OW  = $clog2(HEAP_BYTES + 1);
    localparam int SW  = SIZE_W + 1;
    localparam int LA  = $clog2(ALIGN_BYTES);
    localparam int HW  = $clog2(HEADER_BYTES + 1);
    localparam int PW  = ((LA > HW) ? LA : HW) + 2;
    localparam int XW  = ((OW > SW) ? OW : SW) + 2;

    typedef struct packed {
        logic [OW-1:0] start;
        logic [OW-1:0] len;
        logic          free;
    } t_entry;

    t_entry            mem [MAX_BLOCKS];
    t_entry            r_q;
    logic [ADDR_W-1:0] r_base;
    logic [OPC_W-1:0]  r_op;
    logic              r_aligned;
    logic [SW-1:0]     r_size;
    logic [ADDR_W-1:0] r_off;
    logic [CW-1:0]     r_k;
    logic [CW-1:0]     r_j;
    logic [CW-1:0]     r_count;
    logic [OW-1:0]     r_top;
    logic [OW-1:0]     r_cur_start;
    logic [OW-1:0]     r_cur_len;
    logic [ADDR_W-1:0] r_res_addr;
    logic [ST_W-1:0]   r_res_st;
    logic [ADDR_W-1:0] r_out_addr;
    logic [ST_W-1:0]   r_out_st;

    logic              we;
    logic [CW-1:0]     wr_idx;
    t_entry            wdata;
    logic              re;
    logic [CW-1:0]     rd_idx;

    logic [ADDR_W-1:0] pay_top;
    logic [ADDR_W-1:0] pay_q;
    logic [LA-1:0]     rem_top;
    logic [PW-1:0]     pad0;
    logic [PW-1:0]     pad_t;
    logic [PW-1:0]     pad;
    logic [XW-1:0]     need_sum;
    logic [CW:0]       need_cnt;
    logic [SW-1:0]     size_in;
    logic [SW-1:0]     size_rnd;
    logic [OW-1:0]     abs_b_len;
    logic [OW-1:0]     abs_f_len;

    // Payload addresses and alignment pad of the heap top
    always_comb begin
        pay_top = r_base + ADDR_W'(r_top) + ADDR_W'(HEADER_BYTES);
        pay_q   = r_base + ADDR_W'(r_q.start) + ADDR_W'(HEADER_BYTES);
        rem_top = pay_top[LA-1:0];
        pad0    = (rem_top != '0) ? (PW'(ALIGN_BYTES) - PW'(rem_top)) : '0;
        pad_t   = PW'(HEADER_BYTES) - pad0 + PW'(ALIGN_BYTES - 1);
        pad_t   = (pad_t >> LA) << LA;
        if (!r_aligned) begin
            pad = '0;
        end else if (r_count == '0 && pad0 != '0 && pad0 < PW'(HEADER_BYTES)) begin
            pad = pad0 + pad_t;
        end else begin
            pad = pad0;
        end
        need_sum = XW'(r_top) + XW'(pad) + XW'(HEADER_BYTES) + XW'(r_size);
        need_cnt = {1'b0, r_count} + ((pad != '0 && r_count == '0) ? (CW+1)'(2)
                                                                    : (CW+1)'(1));
    end

    // Round the size of an aligned request up to the alignment
    always_comb begin
        size_in  = SW'(i_alloc_size);
        size_rnd = (size_in + SW'(ALIGN_BYTES - 1)) & ~SW'(ALIGN_BYTES - 1);
    end

    assign abs_b_len = r_q.len + OW'(HEADER_BYTES) + r_cur_len;
    assign abs_f_len = r_cur_len + OW'(HEADER_BYTES) + r_q.len;

    // Status back to the controller
    always_comb begin
        o_status.op        = r_op;
        o_status.scan_end  = (r_k == r_count);
        o_status.hit       = r_q.free && (XW'(r_q.len) >= XW'(r_size)) &&
                             (XW'(r_q.len >> 1) < XW'(r_size)) &&
                             (!r_aligned || pay_q[LA-1:0] == '0);
        o_status.match     = (ADDR_W'(r_q.start) == r_off);
        o_status.q_free    = r_q.free;
        o_status.fits      = (need_sum <= XW'(HEAP_BYTES)) &&
                             (need_cnt <= (CW+1)'(MAX_BLOCKS));
        o_status.pad_nz    = (pad != '0);
        o_status.tbl_empty = (r_count == '0);
        o_status.k_zero    = (r_k == '0);
        o_status.k_last    = (({1'b0, r_k} + (CW+1)'(1)) >= {1'b0, r_count});
        o_status.j_last    = (({1'b0, r_j} + (CW+1)'(1)) >= {1'b0, r_count});
    end

    // Table port selection
    always_comb begin
        we     = 1'b0;
        wr_idx = r_k;
        wdata  = r_q;
        re     = 1'b0;
        rd_idx = r_k;
        case (i_cmd)
            DP_RD_K: begin
                re = 1'b1;
            end
            DP_RD_LAST: begin
                re     = 1'b1;
                rd_idx = r_count - CW'(1);
            end
            DP_RD_KM1: begin
                re     = 1'b1;
                rd_idx = r_k - CW'(1);
            end
            DP_RD_KP1: begin
                re     = 1'b1;
                rd_idx = r_k + CW'(1);
            end
            DP_RD_J1: begin
                re     = 1'b1;
                rd_idx = r_j + CW'(1);
            end
            DP_HIT: begin
                we    = 1'b1;
                wdata = '{start: r_q.start, len: r_q.len, free: 1'b0};
            end
            DP_GROW: begin
                we     = 1'b1;
                wr_idx = r_count - CW'(1);
                wdata  = '{start: r_q.start, len: r_q.len + OW'(pad), free: r_q.free};
            end
            DP_PAD_BLK: begin
                we     = 1'b1;
                wr_idx = '0;
                wdata  = '{start: r_top, len: OW'(pad - PW'(HEADER_BYTES)), free: 1'b1};
            end
            DP_APPEND: begin
                we     = 1'b1;
                wr_idx = r_count;
                wdata  = '{start: r_top, len: OW'(r_size), free: 1'b0};
            end
            DP_MARK: begin
                we    = 1'b1;
                wdata = '{start: r_q.start, len: r_q.len, free: 1'b1};
            end
            DP_ABS_B: begin
                we     = 1'b1;
                wr_idx = r_k - CW'(1);
                wdata  = '{start: r_q.start, len: abs_b_len, free: 1'b1};
            end
            DP_ABS_F: begin
                we    = 1'b1;
                wdata = '{start: r_cur_start, len: abs_f_len, free: 1'b1};
            end
            DP_WR_J: begin
                we     = 1'b1;
                wr_idx = r_j;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    // Block table memory, registered read
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wr_idx[IW-1:0]] <= wdata;
        end
        if (re) begin
            r_q <= mem[rd_idx[IW-1:0]];
        end
    end

    // Control registers: heap base, counters, heap top
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= HEAP_BASE_RESET;
            r_count <= '0;
            r_top   <= '0;
            r_k     <= '0;
            r_j     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_base <= i_cfg_data;
            end
            case (i_cmd)
                DP_LOAD: begin
                    r_k <= '0;
                end
                DP_K_INC: begin
                    r_k <= r_k + CW'(1);
                end
                DP_GROW: begin
                    r_top <= r_top + OW'(pad);
                end
                DP_PAD_BLK: begin
                    r_top   <= r_top + OW'(pad);
                    r_count <= CW'(1);
                end
                DP_APPEND: begin
                    r_top   <= r_top + OW'(HEADER_BYTES) + OW'(r_size);
                    r_count <= r_count + CW'(1);
                end
                DP_ABS_B: begin
                    r_j <= r_k;
                    r_k <= r_k - CW'(1);
                end
                DP_ABS_F: begin
                    r_j <= r_k + CW'(1);
                end
                DP_WR_J: begin
                    r_j <= r_j + CW'(1);
                end
                DP_DEC_COUNT: begin
                    r_count <= r_count - CW'(1);
                end
                default: begin
                    r_k <= r_k;
                end
            endcase
        end
    end

    // Request, merge and result payload registers
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            DP_LOAD: begin
                r_op       <= i_opcode;
                r_aligned  <= (i_opcode == OP_ALLOC_ALIGNED);
                r_size     <= (i_opcode == OP_ALLOC_ALIGNED) ? size_rnd : size_in;
                r_off      <= i_free_address - r_base - ADDR_W'(HEADER_BYTES);
                r_res_addr <= '0;
                r_res_st   <= ST_OK;
            end
            DP_HIT: begin
                r_res_addr <= pay_q;
            end
            DP_APPEND: begin
                r_res_addr <= pay_top;
            end
            DP_ERR_SPACE: begin
                r_res_st <= ST_NO_SPACE;
            end
            DP_ERR_ADDR: begin
                r_res_st <= ST_UNKNOWN;
            end
            DP_MARK: begin
                r_cur_start <= r_q.start;
                r_cur_len   <= r_q.len;
            end
            DP_ABS_B: begin
                r_cur_start <= r_q.start;
                r_cur_len   <= abs_b_len;
            end
            DP_ABS_F: begin
                r_cur_len <= abs_f_len;
            end
            DP_PUSH: begin
                r_out_addr <= r_res_addr;
                r_out_st   <= r_res_st;
            end
            default: begin
                r_res_st <= r_res_st;
            end
        endcase
    end

    assign o_heap_base       = r_base;
    assign o_payload_address = r_out_addr;
    assign o_status_code     = r_out_st;

endmodule

// ----- rtl/ffbha_controller.sv -----
// Controller of the heap allocator: sequences table scans, appends, merges
// and entry shifts, and owns the input and output handshakes.
// Depends on ffbha_pkg.
module ffbha_controller
    import ffbha_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_ASCAN,
        S_ACHK,
        S_AMISS,
        S_AGROW,
        S_APPEND,
        S_FSCAN,
        S_FCHK,
        S_BACK,
        S_BCHK,
        S_FWD,
        S_FCHK2,
        S_SHIFT,
        S_SWR,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_fwd;
    logic   n_fwd;
    logic   r_out_valid;
    logic   n_out_valid;

    // Next state and command decode
    always_comb begin
        n_state     = r_state;
        n_fwd       = r_fwd;
        n_out_valid = r_out_valid;
        o_cmd       = DP_NOP;
        o_in_ready  = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd   = DP_LOAD;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_status.op == OP_ALLOC || i_status.op == OP_ALLOC_ALIGNED) begin
                    n_state = S_ASCAN;
                end else if (i_status.op == OP_FREE) begin
                    n_state = S_FSCAN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_ASCAN: begin
                if (i_status.scan_end) begin
                    n_state = S_AMISS;
                end else begin
                    o_cmd   = DP_RD_K;
                    n_state = S_ACHK;
                end
            end
            S_ACHK: begin
                if (i_status.hit) begin
                    o_cmd   = DP_HIT;
                    n_state = S_DONE;
                end else begin
                    o_cmd   = DP_K_INC;
                    n_state = S_ASCAN;
                end
            end
            S_AMISS: begin
                if (!i_status.fits) begin
                    o_cmd   = DP_ERR_SPACE;
                    n_state = S_DONE;
                end else if (!i_status.pad_nz) begin
                    o_cmd   = DP_APPEND;
                    n_state = S_DONE;
                end else if (i_status.tbl_empty) begin
                    o_cmd   = DP_PAD_BLK;
                    n_state = S_APPEND;
                end else begin
                    o_cmd   = DP_RD_LAST;
                    n_state = S_AGROW;
                end
            end
            S_AGROW: begin
                o_cmd   = DP_GROW;
                n_state = S_APPEND;
            end
            S_APPEND: begin
                o_cmd   = DP_APPEND;
                n_state = S_DONE;
            end
            S_FSCAN: begin
                if (i_status.scan_end) begin
                    o_cmd   = DP_ERR_ADDR;
                    n_state = S_DONE;
                end else begin
                    o_cmd   = DP_RD_K;
                    n_state = S_FCHK;
                end
            end
            S_FCHK: begin
                if (i_status.match) begin
                    o_cmd   = DP_MARK;
                    n_state = S_BACK;
                end else begin
                    o_cmd   = DP_K_INC;
                    n_state = S_FSCAN;
                end
            end
            S_BACK: begin
                if (i_status.k_zero) begin
                    n_state = S_FWD;
                end else begin
                    o_cmd   = DP_RD_KM1;
                    n_state = S_BCHK;
                end
            end
            S_BCHK: begin
                if (i_status.q_free) begin
                    o_cmd   = DP_ABS_B;
                    n_fwd   = 1'b0;
                    n_state = S_SHIFT;
                end else begin
                    n_state = S_FWD;
                end
            end
            S_FWD: begin
                if (i_status.k_last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd   = DP_RD_KP1;
                    n_state = S_FCHK2;
                end
            end
            S_FCHK2: begin
                if (i_status.q_free) begin
                    o_cmd   = DP_ABS_F;
                    n_fwd   = 1'b1;
                    n_state = S_SHIFT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                if (i_status.j_last) begin
                    o_cmd   = DP_DEC_COUNT;
                    n_state = r_fwd ? S_FWD : S_BACK;
                end else begin
                    o_cmd   = DP_RD_J1;
                    n_state = S_SWR;
                end
            end
            S_SWR: begin
                o_cmd   = DP_WR_J;
                n_state = S_SHIFT;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd       = DP_PUSH;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and the output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fwd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fwd       <= n_fwd;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- test/first_fit_block_heap_allocator_tb.sv -----
// Testbench for first_fit_block_heap_allocator: directed table then random
// requests, each result checked against an in-bench model of the heap table or a typed expectation.
// Depends on ffbha_pkg and the RTL top level only.
`timescale 1ns / 100ps

module first_fit_block_heap_allocator_tb
    import ffbha_pkg::*;
;

    localparam int MAX_BLOCKS   = 64;
    localparam int HEAP_BYTES   = 1048576;
    localparam int HEADER_BYTES = 12;
    localparam int ALIGN_BYTES  = 4096;
    localparam int RANDOM_ITEMS = 1850;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [ST_W-1:0]   st;
    } t_grant;

    typedef struct {
        logic [OPC_W-1:0]  op;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] faddr;
        bit                free_last;   // free the most recent grant
        bit                typed;       // expectation typed in the row
        t_grant            want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Heap table shadow
    logic [31:0] heap_base;
    logic [31:0] blk_start [MAX_BLOCKS];
    logic [31:0] blk_len   [MAX_BLOCKS];
    bit          blk_free  [MAX_BLOCKS];
    int          blk_count;
    longint      top_off;
    logic [31:0] last_grant;

    t_grant      grant_q[$];
    int          mismatches;
    logic [15:0] stall_pat;
    int          stall_age;

    first_fit_block_heap_allocator DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    initial begin
        #100ms;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [31:0] payload_at(longint off);
        return heap_base + off[31:0] + HEADER_BYTES;
    endfunction

    // Remove entry k, shifting the rest down
    function automatic void drop_blk(int k);
        for (int j = k; j + 1 < blk_count; j++) begin
            blk_start[j] = blk_start[j+1];
            blk_len[j]   = blk_len[j+1];
            blk_free[j]  = blk_free[j+1];
        end
        blk_count--;
    endfunction

    function automatic t_grant heap_alloc(longint size, bit aligned);
        t_grant g;
        longint pad;
        int     need;
        logic [31:0] rem;
        g = '{addr: '0, st: ST_OK};
        pad = 0;
        need = 1;
        // First fit among free blocks, no split
        for (int k = 0; k < blk_count; k++) begin
            if (blk_free[k] && longint'(blk_len[k]) >= size &&
                longint'(blk_len[k] / 2) < size &&
                (!aligned || payload_at(blk_start[k]) % ALIGN_BYTES == 0)) begin
                blk_free[k] = 1'b0;
                g.addr = payload_at(blk_start[k]);
                return g;
            end
        end
        if (aligned) begin
            rem = payload_at(top_off) % ALIGN_BYTES;
            pad = (rem != 0) ? longint'(ALIGN_BYTES - rem) : 0;
            if (pad != 0 && blk_count == 0) begin
                while (pad < HEADER_BYTES) pad += ALIGN_BYTES;
                need = 2;
            end
        end
        if (top_off + pad + HEADER_BYTES + size > HEAP_BYTES ||
            blk_count + need > MAX_BLOCKS) begin
            g.st = ST_NO_SPACE;
            return g;
        end
        if (pad != 0) begin
            if (blk_count == 0) begin
                blk_start[0] = top_off[31:0];
                blk_len[0]   = 32'(pad - HEADER_BYTES);
                blk_free[0]  = 1'b1;
                blk_count    = 1;
            end else begin
                blk_len[blk_count-1] += pad[31:0];
            end
            top_off += pad;
        end
        blk_start[blk_count] = top_off[31:0];
        blk_len[blk_count]   = size[31:0];
        blk_free[blk_count]  = 1'b0;
        blk_count++;
        g.addr = payload_at(top_off);
        top_off += HEADER_BYTES + size;
        return g;
    endfunction

    function automatic t_grant heap_free(logic [31:0] address);
        t_grant g;
        logic [31:0] off;
        int k;
        g = '{addr: '0, st: ST_OK};
        off = address - heap_base - HEADER_BYTES;
        for (k = 0; k < blk_count; k++)
            if (blk_start[k] == off) break;
        if (k >= blk_count) begin
            g.st = ST_UNKNOWN;
            return g;
        end
        // Coalesce backward, then forward
        blk_free[k] = 1'b1;
        while (k > 0 && blk_free[k-1]) begin
            blk_len[k-1] += HEADER_BYTES + blk_len[k];
            drop_blk(k);
            k--;
        end
        while (k + 1 < blk_count && blk_free[k+1]) begin
            blk_len[k] += HEADER_BYTES + blk_len[k+1];
            drop_blk(k + 1);
        end
        return g;
    endfunction

    function automatic t_grant heap_request(logic [1:0] op, logic [20:0] size,
                                            logic [31:0] faddr);
        t_grant g;
        longint sz;
        g = '{addr: '0, st: ST_OK};
        sz = size;
        if (op == OP_ALLOC) begin
            g = heap_alloc(sz, 1'b0);
        end else if (op == OP_ALLOC_ALIGNED) begin
            if (sz % ALIGN_BYTES != 0) sz = (sz / ALIGN_BYTES + 1) * ALIGN_BYTES;
            g = heap_alloc(sz, 1'b1);
        end else if (op == OP_FREE) begin
            g = heap_free(faddr);
        end
        if (g.st != ST_OK) g.addr = '0;
        return g;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Check each result item against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (grant_q.size() == 0) begin
                report_mismatch("unexpected result", m_tdata[31:0], '0);
            end else begin
                if (m_tdata[31:0] !== grant_q[0].addr)
                    report_mismatch("payload_address", m_tdata[31:0], grant_q[0].addr);
                if (m_tdata[33:32] !== grant_q[0].st)
                    report_mismatch("status", 32'(m_tdata[33:32]), 32'(grant_q[0].st));
                void'(grant_q.pop_front());
            end
        end
    end

    // Receiver stalls on a rotating pattern, renewed now and then
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready  <= 1'b0;
            stall_pat <= 16'hFFFF;
            stall_age <= 0;
        end else begin
            m_tready <= stall_pat[0];
            if (stall_age == 300) begin
                stall_age <= 0;
                if ($urandom_range(3) == 0) begin
                    stall_pat <= 16'h0001;
                end else begin
                    stall_pat <= ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom);
                end
            end else begin
                stall_age <= stall_age + 1;
                stall_pat <= {stall_pat[0], stall_pat[15:1]};
            end
        end
    end

    task automatic write_base(logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= '0;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        heap_base = value;
    endtask

    // Present one item and hold it until taken; predict at acceptance
    task automatic send_item(t_row row);
        logic [31:0] fa;
        t_grant g;
        fa = row.free_last ? last_grant : row.faddr;
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, fa, row.size, row.op};
        do @(posedge i_clk); while (!(s_tvalid && s_tready));
        g = heap_request(row.op, row.size, fa);
        if (g.st == ST_OK && row.op != OP_FREE) last_grant = g.addr;
        grant_q.push_back(row.typed ? row.want : g);
    endtask

    task automatic gap_maybe(ref int burst);
        int idle;
        if (burst > 0) begin
            burst--;
        end else begin
            burst = $urandom_range(0, 30);
            idle  = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
    endtask

    function automatic t_row random_row();
        t_row r;
        int pick;
        r = '{op: OP_ALLOC, size: '0, faddr: $urandom, free_last: 0, typed: 0,
              want: '0};
        pick = $urandom_range(99);
        if (pick < 50) begin
            r.size = ($urandom_range(19) == 0) ? SIZE_W'($urandom_range(0, 20000))
                                               : SIZE_W'($urandom_range(0, 300));
        end else if (pick < 54) begin
            r.op   = OP_ALLOC_ALIGNED;
            r.size = SIZE_W'($urandom_range(0, 5000));
        end else if (pick < 90) begin
            r.op = OP_FREE;
            if (blk_count > 0)
                r.faddr = payload_at(blk_start[$urandom_range(0, blk_count - 1)]);
        end else if (pick < 95) begin
            r.op = OP_FREE;
        end else if (pick < 98) begin
            r.op   = OP_RSVD;
            r.size = SIZE_W'($urandom);
        end else begin
            r.size = SIZE_W'($urandom);
        end
        return r;
    endfunction

    task automatic drain();
        s_tvalid <= 1'b0;
        while (grant_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    t_row directed [$] = '{
        '{OP_ALLOC_ALIGNED, 21'd0,       32'd0, 0, 0, '0},
        '{OP_ALLOC,         21'd0,       32'd0, 0, 0, '0},
        '{OP_ALLOC_ALIGNED, 21'd1,       32'd0, 0, 0, '0},
        '{OP_ALLOC,         21'd100,     32'd0, 0, 0, '0},
        '{OP_FREE,          21'd0,       32'd0, 1, 0, '0},
        '{OP_ALLOC,         21'd60,      32'd0, 0, 0, '0},
        '{OP_ALLOC,         21'd50,      32'd0, 0, 0, '0},
        '{OP_FREE,          21'd0,       32'd0, 1, 0, '0},
        '{OP_FREE,          21'd0,       32'd0, 1, 0, '0},
        '{OP_ALLOC,         21'd1048576, 32'd0, 0, 1, '{32'd0, ST_NO_SPACE}},
        '{OP_ALLOC,         21'h1FFFFF,  32'd0, 0, 1, '{32'd0, ST_NO_SPACE}},
        '{OP_ALLOC_ALIGNED, 21'h1FFFFF,  32'd0, 0, 1, '{32'd0, ST_NO_SPACE}},
        '{OP_FREE,          21'd0,       32'd0, 0, 1, '{32'd0, ST_UNKNOWN}},
        '{OP_FREE,          21'd0,       32'hFFFFFFFF, 0, 1, '{32'd0, ST_UNKNOWN}},
        '{OP_RSVD,          21'h1FFFFF,  32'hFFFFFFFF, 0, 1, '{32'd0, ST_OK}},
        '{OP_ALLOC_ALIGNED, 21'd4097,    32'd0, 0, 0, '0},
        '{OP_FREE,          21'd0,       32'd0, 1, 0, '0},
        '{OP_ALLOC_ALIGNED, 21'd4096,    32'd0, 0, 0, '0},
        '{OP_ALLOC,         21'd4000,    32'd0, 0, 0, '0}
    };

    logic [31:0] phase_base [4] = '{32'd0, 32'hFFFFF000, 32'h0, 32'hFFFFFFFF};

    initial begin
        int burst;
        i_rst_n    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        heap_base  = HEAP_BASE_RESET;
        blk_count  = 0;
        top_off    = 0;
        last_grant = '0;
        mismatches = 0;
        burst      = 0;
        phase_base[2] = $urandom;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Base chosen so the first aligned pad is shorter than a header
        write_base(32'd4078);
        foreach (directed[i]) begin
            send_item(directed[i]);
            gap_maybe(burst);
        end
        drain();

        // Random phases, each under its own heap base
        for (int p = 0; p < 4; p++) begin
            write_base(phase_base[p]);
            for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
                send_item(random_row());
                gap_maybe(burst);
            end
            drain();
        end

        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && grant_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
